### design/dltq_pkg.sv
package dltq_pkg;

    localparam int CAPACITY     = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int DELAY_BITS   = 16;
    localparam int IDX_BITS     = $clog2(CAPACITY);
    localparam int COUNT_BITS   = $clog2(CAPACITY + 1);
    localparam int CMD_BITS     = 2;
    localparam int STATUS_BITS  = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_INSERT = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_QUERY  = 2'd3
    } dltq_cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } dltq_status_t;

    typedef struct packed {
        logic load;
        logic walk_step;
        logic apply;
        logic report;
    } dltq_ctrl_t;

    typedef struct packed {
        logic start_walk;
        logic walk_done;
        logic out_free;
    } dltq_stat_t;

endpackage

### design/delta_list_timer_queue_top.sv
// Bounded delta-list timer queue of CAPACITY entries, one request at a time. Each request
// gives exactly one result. Tick, remove, query and a refused insert pass from acceptance
// through the apply and report states to the result register; an accepted insert first
// walks the list, comparing one stored delta per cycle, and the report state waits for
// a free result register. A new request is taken as soon as the previous one has been
// written to the result register, even if that result still waits on m_ready.
module delta_list_timer_queue_top
    import dltq_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [CMD_BITS-1:0]     s_cmd,
    input  logic [PAYLOAD_BITS-1:0] s_payload,
    input  logic [DELAY_BITS-1:0]   s_delay,
    input  logic [DELAY_BITS-1:0]   s_tick_amount,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [STATUS_BITS-1:0]  m_status,
    output logic [PAYLOAD_BITS-1:0] m_removed_payload,
    output logic [PAYLOAD_BITS-1:0] m_head_payload,
    output logic [DELAY_BITS-1:0]   m_head_delay,
    output logic                    m_queue_empty,
    output logic [COUNT_BITS-1:0]   m_entry_count
);

    dltq_ctrl_t ctrl;
    dltq_stat_t stat;

    dltq_controller u_controller (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    dltq_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctrl              (ctrl),
        .stat              (stat),
        .s_cmd             (s_cmd),
        .s_payload         (s_payload),
        .s_delay           (s_delay),
        .s_tick_amount     (s_tick_amount),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_removed_payload (m_removed_payload),
        .m_head_payload    (m_head_payload),
        .m_head_delay      (m_head_delay),
        .m_queue_empty     (m_queue_empty),
        .m_entry_count     (m_entry_count)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while the previous one is still in progress");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_queue_empty == (m_entry_count == '0))
                    && (m_entry_count <= COUNT_BITS'(CAPACITY)))
        else $error("entry count and empty flag disagree");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STAT_FULL) |-> (m_entry_count == COUNT_BITS'(CAPACITY)))
        else $error("insert refused while the queue had room");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_queue_empty) |-> (m_head_payload == '0 && m_head_delay == '0))
        else $error("empty queue reports a nonzero head");

endmodule

### design/dltq_controller.sv
module dltq_controller
    import dltq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dltq_stat_t stat,
    output dltq_ctrl_t ctrl
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WALK   = 4'b0010,
        ST_APPLY  = 4'b0100,
        ST_REPORT = 4'b1000
    } dltq_state_t;

    dltq_state_t state_reg;
    dltq_state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        ctrl           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ctrl.load  = 1'b1;
                    state_next = stat.start_walk ? ST_WALK : ST_APPLY;
                end
            end
            ST_WALK: begin
                if (stat.walk_done) begin
                    state_next = ST_APPLY;
                end else begin
                    ctrl.walk_step = 1'b1;
                end
            end
            ST_APPLY: begin
                ctrl.apply = 1'b1;
                state_next = ST_REPORT;
            end
            ST_REPORT: begin
                if (stat.out_free) begin
                    ctrl.report = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### design/dltq_datapath.sv
module dltq_datapath
    import dltq_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dltq_ctrl_t              ctrl,
    output dltq_stat_t              stat,
    input  logic [CMD_BITS-1:0]     s_cmd,
    input  logic [PAYLOAD_BITS-1:0] s_payload,
    input  logic [DELAY_BITS-1:0]   s_delay,
    input  logic [DELAY_BITS-1:0]   s_tick_amount,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [STATUS_BITS-1:0]  m_status,
    output logic [PAYLOAD_BITS-1:0] m_removed_payload,
    output logic [PAYLOAD_BITS-1:0] m_head_payload,
    output logic [DELAY_BITS-1:0]   m_head_delay,
    output logic                    m_queue_empty,
    output logic [COUNT_BITS-1:0]   m_entry_count
);

    logic [PAYLOAD_BITS-1:0] pay_reg [CAPACITY];
    logic [DELAY_BITS-1:0]   dly_reg [CAPACITY];

    dltq_cmd_t               cmd_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [DELAY_BITS-1:0]   rem_reg;
    logic [DELAY_BITS-1:0]   amt_reg;
    logic [COUNT_BITS-1:0]   pos_reg;
    logic [COUNT_BITS-1:0]   occ_reg;
    logic [COUNT_BITS-1:0]   occ_next;
    dltq_status_t            status_reg;
    dltq_status_t            status_next;
    logic [PAYLOAD_BITS-1:0] removed_reg;
    logic [PAYLOAD_BITS-1:0] removed_next;

    logic                    m_valid_reg;
    dltq_status_t            m_status_reg;
    logic [PAYLOAD_BITS-1:0] m_removed_reg;
    logic [PAYLOAD_BITS-1:0] m_head_payload_reg;
    logic [DELAY_BITS-1:0]   m_head_delay_reg;
    logic                    m_empty_reg;
    logic [COUNT_BITS-1:0]   m_count_reg;

    logic [DELAY_BITS-1:0]   cur_delta;
    logic                    is_full;
    logic                    is_empty;

    assign is_full   = (occ_reg >= COUNT_BITS'(CAPACITY));
    assign is_empty  = (occ_reg == '0);
    assign cur_delta = dly_reg[pos_reg[IDX_BITS-1:0]];

    assign stat.start_walk = (s_cmd == CMD_INSERT) && !is_full;
    assign stat.walk_done  = !((pos_reg < occ_reg) && (cur_delta <= rem_reg));
    assign stat.out_free   = !m_valid_reg || m_ready;

    always_comb begin
        status_next  = STAT_OK;
        removed_next = '0;
        occ_next     = occ_reg;
        case (cmd_reg)
            CMD_INSERT: begin
                if (is_full) begin
                    status_next = STAT_FULL;
                end else begin
                    occ_next = occ_reg + COUNT_BITS'(1);
                end
            end
            CMD_TICK: begin
                if (is_empty) begin
                    status_next = STAT_EMPTY;
                end
            end
            CMD_REMOVE: begin
                if (is_empty) begin
                    status_next = STAT_EMPTY;
                end else begin
                    removed_next = pay_reg[0];
                    occ_next     = occ_reg - COUNT_BITS'(1);
                end
            end
            default: begin
                status_next = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg     <= dltq_cmd_t'(s_cmd);
            payload_reg <= s_payload;
            rem_reg     <= s_delay;
            amt_reg     <= s_tick_amount;
        end else if (ctrl.walk_step) begin
            rem_reg <= rem_reg - cur_delta;
        end
        if (ctrl.apply) begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            occ_reg <= '0;
        end else begin
            if (ctrl.load) begin
                pos_reg <= '0;
            end else if (ctrl.walk_step) begin
                pos_reg <= pos_reg + COUNT_BITS'(1);
            end
            if (ctrl.apply) begin
                occ_reg <= occ_next;
            end
        end
    end

    // Entries shift one place toward the tail on insert and toward the head on remove.
    always_ff @(posedge aclk) begin
        if (ctrl.apply) begin
            case (cmd_reg)
                CMD_INSERT: begin
                    if (!is_full) begin
                        if (pos_reg == '0) begin
                            pay_reg[0] <= payload_reg;
                            dly_reg[0] <= rem_reg;
                        end
                        for (int k = 1; k < CAPACITY; k++) begin
                            if (COUNT_BITS'(k) == pos_reg) begin
                                pay_reg[k] <= payload_reg;
                                dly_reg[k] <= rem_reg;
                            end else if (COUNT_BITS'(k) > pos_reg
                                         && COUNT_BITS'(k) <= occ_reg) begin
                                pay_reg[k] <= pay_reg[k-1];
                                if (COUNT_BITS'(k) == pos_reg + COUNT_BITS'(1)) begin
                                    dly_reg[k] <= dly_reg[k-1] - rem_reg;
                                end else begin
                                    dly_reg[k] <= dly_reg[k-1];
                                end
                            end
                        end
                    end
                end
                CMD_TICK: begin
                    if (!is_empty) begin
                        dly_reg[0] <= (dly_reg[0] > amt_reg) ? dly_reg[0] - amt_reg : '0;
                    end
                end
                CMD_REMOVE: begin
                    if (!is_empty) begin
                        for (int k = 0; k < CAPACITY - 1; k++) begin
                            pay_reg[k] <= pay_reg[k+1];
                            dly_reg[k] <= dly_reg[k+1];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.report) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.report) begin
            m_status_reg       <= status_reg;
            m_removed_reg      <= removed_reg;
            m_head_payload_reg <= is_empty ? '0 : pay_reg[0];
            m_head_delay_reg   <= is_empty ? '0 : dly_reg[0];
            m_empty_reg        <= is_empty;
            m_count_reg        <= occ_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_removed_payload = m_removed_reg;
    assign m_head_payload    = m_head_payload_reg;
    assign m_head_delay      = m_head_delay_reg;
    assign m_queue_empty     = m_empty_reg;
    assign m_entry_count     = m_count_reg;

endmodule
